### src/pei_pkg.sv
// shared types and constants for the insertion-order permutation enumerator
// no dependencies; used by every module of the block
package pei_pkg;

  // fixed field widths of the result channel
  localparam int ELEM_W   = 4;
  localparam int NUM_ELEM = 8;
  localparam int RANK_W   = 16;

  // size register
  localparam int          CFG_W      = 4;
  localparam logic [3:0]  SIZE_RESET = 4'd5;

  // sequencer to datapath control
  typedef struct packed {
    logic start;    // item accepted, latch flags and advance rank
    logic restart;  // accepted item asks for the first permutation
    logic step;     // one insertion of the current value
  } ctrl_t;

endpackage

### src/pei_digit_file.sv
// insert-position digits, rank counter and carry flags of the enumerator
// depends on pei_pkg
module pei_digit_file #(
  parameter int MAX_SIZE = 8,
  parameter int VW       = 4,
  parameter int DW       = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pei_pkg::ctrl_t            ctrl,
  input  logic [VW-1:0]             k,
  input  logic [VW-1:0]             v,
  output logic [DW-1:0]             pos_o,
  output logic                      last_o,
  output logic [pei_pkg::RANK_W-1:0] rank_o
);

  logic [DW-1:0]              dig_r [MAX_SIZE];
  logic [pei_pkg::RANK_W-1:0] rank_r;
  logic [pei_pkg::RANK_W-1:0] rank_out_r;
  logic                       last_r;
  logic [MAX_SIZE-1:0]        carry_r;

  logic [DW-1:0]              eff_dig [MAX_SIZE];
  logic [MAX_SIZE-1:0]        ge_ext;
  logic [MAX_SIZE-1:0]        eq_ext;
  logic [MAX_SIZE-1:0]        carry_in;
  logic                       wrap;
  logic                       all_max;
  logic [pei_pkg::RANK_W-1:0] rank_eff;
  logic [DW-1:0]              idx;

  // per-digit max flags; digits of values above k count as saturated
  always_comb begin
    for (int u = 0; u < MAX_SIZE; u++) begin
      eff_dig[u] = ctrl.restart ? '0 : dig_r[u];
      if (u == 0) begin
        ge_ext[u] = 1'b1;
        eq_ext[u] = 1'b1;
      end else begin
        ge_ext[u] = (eff_dig[u] >= DW'(u)) || (VW'(u) >= k);
        eq_ext[u] = (eff_dig[u] == DW'(u)) || (VW'(u) >= k);
      end
    end
  end

  // carry into each digit: all faster digits saturated
  always_comb begin
    for (int u = 0; u < MAX_SIZE; u++) begin
      carry_in[u] = 1'b1;
      for (int w = 0; w < MAX_SIZE; w++) begin
        if (w > u) carry_in[u] = carry_in[u] & ge_ext[w];
      end
    end
    wrap    = &ge_ext;
    all_max = &eq_ext;
  end

  assign rank_eff = ctrl.restart ? '0 : rank_r;
  assign idx      = DW'(v - VW'(1));
  assign pos_o    = dig_r[idx];
  assign last_o   = last_r;
  assign rank_o   = rank_out_r;

  // digit and rank state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int u = 0; u < MAX_SIZE; u++) dig_r[u] <= '0;
      rank_r <= '0;
    end else if (ctrl.start) begin
      if (ctrl.restart) begin
        for (int u = 0; u < MAX_SIZE; u++) dig_r[u] <= '0;
      end
      rank_r <= wrap ? '0 : rank_eff + pei_pkg::RANK_W'(1);
    end else if (ctrl.step && carry_r[idx]) begin
      dig_r[idx] <= (dig_r[idx] >= DW'(v - VW'(1))) ? '0 : dig_r[idx] + DW'(1);
    end
  end

  // flags and rank captured for the item in flight
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      carry_r    <= carry_in;
      last_r     <= all_max;
      rank_out_r <= rank_eff;
    end
  end

endmodule

### src/pei_insert_unit.sv
// sequence register with a one-value-per-cycle insertion shifter
// depends on pei_pkg
module pei_insert_unit #(
  parameter int MAX_SIZE = 8,
  parameter int VW       = 4,
  parameter int DW       = 3
) (
  input  logic                                     clk,
  input  pei_pkg::ctrl_t                           ctrl,
  input  logic [VW-1:0]                            v,
  input  logic [DW-1:0]                            pos,
  output logic [MAX_SIZE-1:0][pei_pkg::ELEM_W-1:0] seq_o
);

  logic [MAX_SIZE-1:0][pei_pkg::ELEM_W-1:0] seq_r;
  logic [VW-1:0] len;
  logic [VW-1:0] p;

  // current length is v-1; a digit past the end inserts at the end
  assign len   = v - VW'(1);
  assign p     = (VW'(pos) > len) ? len : VW'(pos);
  assign seq_o = seq_r;

  // start loads the sequence (1); each step opens a slot at p and drops v in
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      seq_r <= (MAX_SIZE * pei_pkg::ELEM_W)'(1);
    end else if (ctrl.step) begin
      if (p == '0) seq_r[0] <= pei_pkg::ELEM_W'(v);
      for (int j = 1; j < MAX_SIZE; j++) begin
        if (VW'(j) == p) begin
          seq_r[j] <= pei_pkg::ELEM_W'(v);
        end else if (VW'(j) > p && VW'(j) <= len) begin
          seq_r[j] <= seq_r[j-1];
        end
      end
    end
  end

endmodule

### src/permutation_enumerator_insertion_core.sv
// Permutation enumerator in insertion order. One input transfer yields one result
// transfer carrying the next permutation of 1..k, its rank and a last flag.
//
// Channels: in_valid/in_stall with in_restart; out_valid/out_stall with
// out_element_0..7, out_perm_rank and out_last_of_run. cfg_we/cfg_wdata write
// the size k (reset 5; 0 acts as 1, values above MAX_SIZE act as MAX_SIZE);
// write it only while the block is idle.
//
// An accepted item runs one insertion in the shared shifter for each value
// 2..k, then its result is loaded into the output register; size one skips
// the insertion pass. A new item is taken once the previous result has been
// loaded into the output register.
// While out_stall holds, the result stays in the output register; a finished
// next item waits in the sequencer and in_stall stays high.
// Reset clears the digits and the rank counter, so the first item yields the
// permutation k down to 1 at rank 0; in_restart does the same for its own item.
// Depends on pei_pkg, pei_digit_file and pei_insert_unit.
module permutation_enumerator_insertion_core #(
  parameter int MAX_SIZE = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pei_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_0,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_1,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_2,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_3,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_4,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_5,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_6,
  output logic [pei_pkg::ELEM_W-1:0]     out_element_7,
  output logic [pei_pkg::RANK_W-1:0]     out_perm_rank,
  output logic                           out_last_of_run
);

  localparam int VW = $clog2(MAX_SIZE + 1);
  localparam int DW = $clog2(MAX_SIZE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [VW-1:0]              v_r, v_nxt;
  logic [pei_pkg::CFG_W-1:0]  size_r;
  logic [VW-1:0]              k;
  logic                       in_xfer;
  logic                       load_out;
  pei_pkg::ctrl_t             ctrl;

  logic [DW-1:0]                            pos;
  logic                                     last;
  logic [pei_pkg::RANK_W-1:0]               rank;
  logic [MAX_SIZE-1:0][pei_pkg::ELEM_W-1:0] seq;

  logic [pei_pkg::ELEM_W-1:0] elem_nxt [pei_pkg::NUM_ELEM];
  logic [pei_pkg::ELEM_W-1:0] elem_r   [pei_pkg::NUM_ELEM];
  logic [pei_pkg::RANK_W-1:0] rank_r;
  logic                       last_r;
  logic                       out_valid_r;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= pei_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // effective size, clamped to 1..MAX_SIZE
  always_comb begin
    if (size_r == '0) begin
      k = VW'(1);
    end else if (size_r > pei_pkg::CFG_W'(MAX_SIZE)) begin
      k = VW'(MAX_SIZE);
    end else begin
      k = VW'(size_r);
    end
  end

  // handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign ctrl.start   = in_xfer;
  assign ctrl.restart = in_xfer && in_restart;
  assign ctrl.step    = (state_r == ST_INS);

  // sequencer: one insertion per cycle for values 2..k
  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          v_nxt     = VW'(2);
          state_nxt = (k == VW'(1)) ? ST_DONE : ST_INS;
        end
      end
      ST_INS: begin
        if (v_r == k) begin
          state_nxt = ST_DONE;
        end else begin
          v_nxt = v_r + VW'(1);
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  pei_digit_file #(
    .MAX_SIZE (MAX_SIZE),
    .VW       (VW),
    .DW       (DW)
  ) u_digits (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .k      (k),
    .v      (v_r),
    .pos_o  (pos),
    .last_o (last),
    .rank_o (rank)
  );

  pei_insert_unit #(
    .MAX_SIZE (MAX_SIZE),
    .VW       (VW),
    .DW       (DW)
  ) u_insert (
    .clk   (clk),
    .ctrl  (ctrl),
    .v     (v_r),
    .pos   (pos),
    .seq_o (seq)
  );

  // positions at or beyond k read zero
  for (genvar g = 0; g < pei_pkg::NUM_ELEM; g++) begin : g_elem
    if (g < MAX_SIZE) begin : g_used
      assign elem_nxt[g] = (VW'(g) < k) ? seq[g] : '0;
    end else begin : g_unused
      assign elem_nxt[g] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < pei_pkg::NUM_ELEM; i++) elem_r[i] <= elem_nxt[i];
      rank_r <= rank;
      last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_element_0   = elem_r[0];
  assign out_element_1   = elem_r[1];
  assign out_element_2   = elem_r[2];
  assign out_element_3   = elem_r[3];
  assign out_element_4   = elem_r[4];
  assign out_element_5   = elem_r[5];
  assign out_element_6   = elem_r[6];
  assign out_element_7   = elem_r[7];
  assign out_perm_rank   = rank_r;
  assign out_last_of_run = last_r;

`ifndef SYNTH
  // size one skips the insertion pass
  a_size_one_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (k == VW'(1)) |=> state_r == ST_DONE)
    else $error("size one item did not go straight to output");

  // the insertion value stays within 2..k
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS |-> (v_r >= VW'(2)) && (v_r <= k))
    else $error("insertion value out of range");

  // a finished item is loaded as soon as the output register is free
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !(out_valid_r && out_stall)
      |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished item not loaded into output register");

  // a taken result with nothing finished behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && (state_r != ST_DONE) |=> !out_valid_r)
    else $error("result repeated after transfer");
`endif

endmodule

### dv/permutation_enumerator_insertion_core_tb.sv
// self-checking testbench for permutation_enumerator_insertion_core
// depends on pei_pkg and the core; predicts each permutation, rank and last flag itself
module permutation_enumerator_insertion_core_tb;

  localparam int MAX_SIZE    = 8;
  localparam int DIG_W       = $clog2(MAX_SIZE);
  localparam int SETTLE_CYC  = 24;
  localparam int HOLD_CYC    = 400;

  typedef struct packed {
    logic [pei_pkg::NUM_ELEM-1:0][pei_pkg::ELEM_W-1:0] elem;
    logic [pei_pkg::RANK_W-1:0]                        rank;
    logic                                              last;
  } perm_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [pei_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [pei_pkg::ELEM_W-1:0] out_element_0, out_element_1, out_element_2, out_element_3;
  logic [pei_pkg::ELEM_W-1:0] out_element_4, out_element_5, out_element_6, out_element_7;
  logic [pei_pkg::RANK_W-1:0] out_perm_rank;
  logic                       out_last_of_run;

  // predictor state
  logic [DIG_W-1:0]           digit_q [MAX_SIZE];
  logic [pei_pkg::RANK_W-1:0] rank_q;
  logic [pei_pkg::CFG_W-1:0]  size_q;

  perm_result_t pending_perms [$];
  int  error_count = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  logic hold_active = 1'b0;
  event hold_trigger;

  permutation_enumerator_insertion_core #(.MAX_SIZE(MAX_SIZE)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_element_0   (out_element_0),
    .out_element_1   (out_element_1),
    .out_element_2   (out_element_2),
    .out_element_3   (out_element_3),
    .out_element_4   (out_element_4),
    .out_element_5   (out_element_5),
    .out_element_6   (out_element_6),
    .out_element_7   (out_element_7),
    .out_perm_rank   (out_perm_rank),
    .out_last_of_run (out_last_of_run)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // build the next permutation from the digits, then advance the counter
  task automatic predict_permutation(input bit restart);
    logic [pei_pkg::ELEM_W-1:0] seq [MAX_SIZE];
    perm_result_t r;
    int k, len, pos, v, j, i;
    bit last, carry;
    k = int'(size_q);
    if (k < 1) k = 1;
    if (k > MAX_SIZE) k = MAX_SIZE;
    if (restart) begin
      for (i = 0; i < MAX_SIZE; i++) digit_q[i] = '0;
      rank_q = '0;
    end
    for (i = 0; i < MAX_SIZE; i++) seq[i] = '0;
    seq[0] = pei_pkg::ELEM_W'(1);
    len = 1;
    last = 1'b1;
    for (v = 2; v <= k; v++) begin
      pos = int'(digit_q[v-1]);
      // a digit past the end inserts at the end
      if (pos > len) pos = len;
      for (j = len; j > pos; j--) seq[j] = seq[j-1];
      seq[pos] = pei_pkg::ELEM_W'(v);
      len++;
      if (digit_q[v-1] != v - 1) last = 1'b0;
    end
    for (i = 0; i < pei_pkg::NUM_ELEM; i++) r.elem[i] = (i < k) ? seq[i] : '0;
    r.rank = rank_q;
    r.last = last;
    pending_perms.push_back(r);
    // mixed-radix advance, value k fastest
    carry = 1'b1;
    for (v = k; v >= 2 && carry; v--) begin
      if (digit_q[v-1] >= v - 1) digit_q[v-1] = '0;
      else begin
        digit_q[v-1] = digit_q[v-1] + DIG_W'(1);
        carry = 1'b0;
      end
    end
    rank_q = carry ? '0 : rank_q + pei_pkg::RANK_W'(1);
  endtask

  // offer one item, with random idle cycles ahead of it; valid stays high afterwards
  task automatic send_item(input bit restart);
    while ($urandom_range(99) < idle_pct) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    predict_permutation(restart);
  endtask

  // stop offering and wait for every expected result plus the pipeline latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_perms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_size(input logic [pei_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_q = value;
  endtask

  task automatic set_pressure(input int idle, input int stall);
    idle_pct  <= idle;
    stall_pct <= stall;
    @(posedge clk);
  endtask

  // mostly small sizes, sometimes the largest, sometimes out of range
  function automatic logic [pei_pkg::CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return pei_pkg::CFG_W'($urandom_range(15, MAX_SIZE + 1));
    if (r < 60) return pei_pkg::CFG_W'($urandom_range(4, 1));
    if (r < 85) return pei_pkg::CFG_W'($urandom_range(6, 5));
    if (r < 95) return pei_pkg::CFG_W'(7);
    return pei_pkg::CFG_W'(MAX_SIZE);
  endfunction

  // reset default size, counter starts at the permutation k down to 1, then a restart
  task automatic test_reset_state();
    int i;
    for (i = 0; i < 4; i++) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    wait_idle();
  endtask

  // size one, zero, two, three, the largest and out of range
  task automatic test_size_edges();
    int i;
    write_size(pei_pkg::CFG_W'(1));
    send_item(1'b0);
    send_item(1'b0);
    write_size(pei_pkg::CFG_W'(0));
    send_item(1'b1);
    send_item(1'b0);
    write_size(pei_pkg::CFG_W'(2));
    for (i = 0; i < 3; i++) send_item(i == 0);
    write_size(pei_pkg::CFG_W'(3));
    for (i = 0; i < 7; i++) send_item(i == 0);
    write_size(pei_pkg::CFG_W'(MAX_SIZE));
    send_item(1'b1);
    send_item(1'b0);
    write_size(pei_pkg::CFG_W'(15));
    send_item(1'b0);
    send_item(1'b0);
  endtask

  // change size without restart, then realign with a restart
  task automatic test_size_change_midrun();
    int i;
    write_size(pei_pkg::CFG_W'(6));
    for (i = 0; i < 9; i++) send_item(i == 0);
    write_size(pei_pkg::CFG_W'(3));
    for (i = 0; i < 4; i++) send_item(1'b0);
    write_size(pei_pkg::CFG_W'(5));
    for (i = 0; i < 4; i++) send_item(1'b0);
    send_item(1'b1);
    wait_idle();
  endtask

  // complete runs through the last permutation and the wrap
  task automatic test_full_enumeration();
    int i;
    write_size(pei_pkg::CFG_W'(4));
    for (i = 0; i < 26; i++) send_item(i == 0);
    write_size(pei_pkg::CFG_W'(5));
    for (i = 0; i < 122; i++) send_item(i == 0);
    wait_idle();
  endtask

  // random bursts of random size, occasional restarts
  task automatic test_random_traffic(input int idle, input int stall, input int count);
    int sent, burst, i;
    set_pressure(idle, stall);
    sent = 0;
    while (sent < count) begin
      write_size(pick_size());
      burst = $urandom_range(60, 10);
      for (i = 0; i < burst; i++) begin
        send_item((i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3));
      end
      sent += burst;
    end
    wait_idle();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure_hold();
    int i;
    set_pressure(0, 0);
    write_size(pei_pkg::CFG_W'(3));
    -> hold_trigger;
    for (i = 0; i < 30; i++) send_item(i == 0);
    wait_idle();
  endtask

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_trigger);
      hold_active <= 1'b1;
      repeat (HOLD_CYC) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_active) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each result transfer with the oldest predicted permutation
  always @(posedge clk) begin
    perm_result_t got, want;
    int i;
    if (rst_n && out_valid && !out_stall) begin
      got.elem = {out_element_7, out_element_6, out_element_5, out_element_4,
                  out_element_3, out_element_2, out_element_1, out_element_0};
      got.rank = out_perm_rank;
      got.last = out_last_of_run;
      if (pending_perms.size() == 0) begin
        $display("%0t: result transfer expected none actual rank %0d", $time, got.rank);
        error_count++;
      end else begin
        want = pending_perms.pop_front();
        for (i = 0; i < pei_pkg::NUM_ELEM; i++) begin
          if (got.elem[i] !== want.elem[i]) begin
            $display("%0t: element_%0d expected %0d actual %0d",
                     $time, i, want.elem[i], got.elem[i]);
            error_count++;
          end
        end
        if (got.rank !== want.rank) begin
          $display("%0t: perm_rank expected %0d actual %0d", $time, want.rank, got.rank);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    int i;
    for (i = 0; i < MAX_SIZE; i++) digit_q[i] = '0;
    rank_q = '0;
    size_q = pei_pkg::SIZE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_size_edges();
    test_size_change_midrun();
    test_full_enumeration();
    test_random_traffic(0, 0, 200);
    test_random_traffic(76, 0, 200);
    test_random_traffic(0, 76, 200);
    test_random_traffic(29, 29, 200);
    test_backpressure_hold();
    wait_idle();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### permutation_enumerator_insertion_core.f
src/pei_pkg.sv
src/pei_digit_file.sv
src/pei_insert_unit.sv
src/permutation_enumerator_insertion_core.sv
dv/permutation_enumerator_insertion_core_tb.sv
